// ===== hdl/tef_pkg.sv =====
`default_nettype none

package tef_pkg;

  localparam int unsigned FIELD_W = 64;
  localparam int unsigned INDEX_W = 48;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned NEST_W  = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned EVENT_W = 4;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 64;

  typedef enum logic [1:0] {
    MODE_PASS     = 2'd0,
    MODE_SINGLE   = 2'd1,
    MODE_RANGE    = 2'd2,
    MODE_FUNCTION = 2'd3
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_OTHER  = 2'd0,
    KIND_CALL   = 2'd1,
    KIND_RETURN = 2'd2
  } kind_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE        = 4'd0,
    EV_PASS        = 4'd1,
    EV_HIT         = 4'd2,
    EV_RANGE_ENTER = 4'd3,
    EV_IN_RANGE    = 4'd4,
    EV_RANGE_EXIT  = 4'd5,
    EV_CALL        = 4'd6,
    EV_IN_FUNCTION = 4'd7,
    EV_RETURN      = 4'd8
  } event_e;

  typedef enum logic [1:0] {
    REG_FILTER_MODE   = 2'd0,
    REG_MATCH_ADDRESS = 2'd1,
    REG_RANGE_END     = 2'd2,
    REG_ROOT_LOCATION = 2'd3
  } reg_e;

  typedef struct packed {
    mode_e              filter_mode;
    logic [FIELD_W-1:0] match_address;
    logic [FIELD_W-1:0] range_end_address;
    logic [FIELD_W-1:0] root_location;
    logic               root_load;
    logic [FIELD_W-1:0] root_load_value;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/tef_if.sv =====
`default_nettype none

interface tef_in_if;
  logic                          valid;
  logic                          ready;
  logic [tef_pkg::KIND_W-1:0]    kind;
  logic [tef_pkg::FIELD_W-1:0]   instr_address;
  logic [tef_pkg::FIELD_W-1:0]   call_target;

  modport source (output valid, kind, instr_address, call_target, input ready);
  modport sink (input valid, kind, instr_address, call_target, output ready);
endinterface

interface tef_out_if;
  logic                          valid;
  logic                          ready;
  logic [tef_pkg::EVENT_W-1:0]   event_res;
  logic [tef_pkg::COUNT_W-1:0]   exec_count;
  logic [tef_pkg::INDEX_W-1:0]   instr_index;
  logic [tef_pkg::FIELD_W-1:0]   caller_location;
  logic [tef_pkg::FIELD_W-1:0]   return_address;

  modport source (output valid, event_res, exec_count, instr_index, caller_location,
                  return_address, input ready);
  modport sink (input valid, event_res, exec_count, instr_index, caller_location,
                return_address, output ready);
endinterface

`default_nettype wire

// ===== hdl/tef_cfg_regs.sv =====
`default_nettype none

module tef_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tef_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tef_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tef_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output tef_pkg::cfg_t                     cfg_o
);

  tef_pkg::mode_e                   mode_q;
  logic [tef_pkg::FIELD_W-1:0]      match_q;
  logic [tef_pkg::FIELD_W-1:0]      range_end_q;
  logic [tef_pkg::FIELD_W-1:0]      root_q;
  logic                             wr_en;
  tef_pkg::reg_e                    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  // registers sit on 8-byte boundaries
  assign reg_sel = tef_pkg::reg_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= tef_pkg::MODE_PASS;
      match_q     <= '0;
      range_end_q <= '0;
      root_q      <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        tef_pkg::REG_FILTER_MODE:   mode_q      <= tef_pkg::mode_e'(pwdata[1:0]);
        tef_pkg::REG_MATCH_ADDRESS: match_q     <= pwdata;
        tef_pkg::REG_RANGE_END:     range_end_q <= pwdata;
        tef_pkg::REG_ROOT_LOCATION: root_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tef_pkg::REG_FILTER_MODE:   prdata = tef_pkg::PDATA_W'(mode_q);
      tef_pkg::REG_MATCH_ADDRESS: prdata = match_q;
      tef_pkg::REG_RANGE_END:     prdata = range_end_q;
      tef_pkg::REG_ROOT_LOCATION: prdata = root_q;
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o.filter_mode       = mode_q;
  assign cfg_o.match_address     = match_q;
  assign cfg_o.range_end_address = range_end_q;
  assign cfg_o.root_location     = root_q;
  assign cfg_o.root_load         = wr_en && (reg_sel == tef_pkg::REG_ROOT_LOCATION);
  assign cfg_o.root_load_value   = pwdata;

endmodule

`default_nettype wire

// ===== hdl/tef_caller_stack.sv =====
`default_nettype none

module tef_caller_stack #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic [IDX_W-1:0] rd_idx_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/tef_engine.sv =====
`default_nettype none

module tef_engine #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned ADDR_WIDTH  = 64,
  localparam int unsigned LVL_W = $clog2(STACK_DEPTH + 1),
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tef_pkg::cfg_t         cfg_i,
  tef_in_if.sink                     in_s,
  tef_out_if.source                  out_s,
  output logic                       stk_wr_en_o,
  output logic      [IDX_W-1:0]      stk_wr_idx_o,
  output logic      [ADDR_WIDTH-1:0] stk_wr_data_o,
  output logic      [IDX_W-1:0]      stk_rd_idx_o,
  input  wire logic [ADDR_WIDTH-1:0] stk_rd_data_i
);

  localparam logic [tef_pkg::INDEX_W-1:0] INDEX_MAX = '1;
  localparam logic [tef_pkg::COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [tef_pkg::NEST_W-1:0]  NEST_MAX  = '1;
  localparam logic [LVL_W-1:0]            LVL_FULL  = LVL_W'(STACK_DEPTH);

  // input register
  logic                          in_valid_q;
  logic [tef_pkg::KIND_W-1:0]    kind_q;
  logic [tef_pkg::FIELD_W-1:0]   iaddr_q;
  logic [tef_pkg::FIELD_W-1:0]   target_q;

  // filter state
  logic [tef_pkg::INDEX_W-1:0]   instr_q, instr_d;
  logic [tef_pkg::COUNT_W-1:0]   hits_q, hits_d;
  logic                          inside_q, inside_d;
  logic [tef_pkg::NEST_W-1:0]    nest_q, nest_d;
  logic [ADDR_WIDTH-1:0]         cap_q, cap_d;
  logic [ADDR_WIDTH-1:0]         cur_q, cur_d;
  logic [LVL_W-1:0]              level_q, level_d;

  // result register
  logic                          out_valid_q;
  tef_pkg::event_e               ev_q, ev_d;
  logic [ADDR_WIDTH-1:0]         caller_q, caller_d;

  logic                          in_fire;
  logic                          adv;
  logic                          bump;
  logic                          first;
  logic                          is_call;
  logic                          is_ret;
  logic [ADDR_WIDTH-1:0]         addr;
  logic [ADDR_WIDTH-1:0]         target;
  logic [ADDR_WIDTH-1:0]         m_addr;
  logic [ADDR_WIDTH-1:0]         e_addr;
  logic [ADDR_WIDTH-1:0]         root;
  logic [LVL_W-1:0]              level_nx;

  assign adv      = in_valid_q && (!out_valid_q || out_s.ready);
  assign in_s.ready = !in_valid_q || adv;
  assign in_fire  = in_s.valid && in_s.ready;

  assign addr    = iaddr_q[ADDR_WIDTH-1:0];
  assign target  = target_q[ADDR_WIDTH-1:0];
  assign m_addr  = cfg_i.match_address[ADDR_WIDTH-1:0];
  assign e_addr  = cfg_i.range_end_address[ADDR_WIDTH-1:0];
  assign root    = cfg_i.root_location[ADDR_WIDTH-1:0];
  assign is_call = (kind_q == tef_pkg::KIND_CALL);
  assign is_ret  = (kind_q == tef_pkg::KIND_RETURN);

  always_comb begin
    instr_d     = (instr_q != INDEX_MAX) ? instr_q + 1'b1 : instr_q;
    first       = (instr_d == tef_pkg::INDEX_W'(1));
    bump        = 1'b0;
    inside_d    = inside_q;
    nest_d      = nest_q;
    cap_d       = cap_q;
    cur_d       = cur_q;
    level_d     = level_q;
    ev_d        = tef_pkg::EV_NONE;
    caller_d    = '0;
    stk_wr_en_o = 1'b0;

    case (cfg_i.filter_mode)
      tef_pkg::MODE_PASS: begin
        ev_d = tef_pkg::EV_PASS;
      end
      tef_pkg::MODE_SINGLE: begin
        if (addr == m_addr) begin
          bump = 1'b1;
          ev_d = tef_pkg::EV_HIT;
        end
      end
      tef_pkg::MODE_RANGE: begin
        if (m_addr <= addr && addr <= e_addr) begin
          if (!inside_q) begin
            inside_d = 1'b1;
            bump     = 1'b1;
            ev_d     = tef_pkg::EV_RANGE_ENTER;
          end else begin
            ev_d = tef_pkg::EV_IN_RANGE;
          end
        end else if (inside_q) begin
          inside_d = 1'b0;
          ev_d     = tef_pkg::EV_RANGE_EXIT;
        end
      end
      tef_pkg::MODE_FUNCTION: begin
        if (!inside_q) begin
          if (is_call) begin
            if (target == m_addr) begin
              inside_d = 1'b1;
              bump     = 1'b1;
              ev_d     = tef_pkg::EV_CALL;
              caller_d = cur_q;
            end else if (!first) begin
              cur_d = target;
              // drop the push when the stack is full
              if (level_q < LVL_FULL) begin
                stk_wr_en_o = adv;
                level_d     = level_q + 1'b1;
              end
            end
          end
          if (is_ret && cur_q != root) begin
            if (level_q != '0) begin
              level_d = level_q - 1'b1;
            end
            // the read port already holds the entry below the top
            if (level_q > LVL_W'(1)) begin
              cur_d = stk_rd_data_i;
            end
          end
        end else begin
          ev_d = tef_pkg::EV_IN_FUNCTION;
          if (is_call && nest_q != NEST_MAX) begin
            nest_d = nest_q + 1'b1;
          end
          if (is_ret) begin
            if (nest_q == '0) begin
              if (cap_q == '0) begin
                cap_d = addr;
              end
              inside_d = 1'b0;
              ev_d     = tef_pkg::EV_RETURN;
            end else begin
              nest_d = nest_q - 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    hits_d = (bump && hits_q != COUNT_MAX) ? hits_q + 1'b1 : hits_q;
  end

  // keep the read port on the entry just below the top of the stack
  assign level_nx      = adv ? level_d : level_q;
  assign stk_rd_idx_o  = IDX_W'(level_nx - LVL_W'(2));
  assign stk_wr_idx_o  = level_q[IDX_W-1:0];
  assign stk_wr_data_o = target;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      instr_q     <= '0;
      hits_q      <= '0;
      inside_q    <= 1'b0;
      nest_q      <= '0;
      cap_q       <= '0;
      cur_q       <= '0;
      level_q     <= '0;
    end else begin
      if (in_s.ready) begin
        in_valid_q <= in_s.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        instr_q  <= instr_d;
        hits_q   <= hits_d;
        inside_q <= inside_d;
        nest_q   <= nest_d;
        cap_q    <= cap_d;
        level_q  <= level_d;
      end
      if (cfg_i.root_load) begin
        cur_q <= cfg_i.root_load_value[ADDR_WIDTH-1:0];
      end else if (adv) begin
        cur_q <= cur_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= in_s.kind;
      iaddr_q  <= in_s.instr_address;
      target_q <= in_s.call_target;
    end
    if (adv) begin
      ev_q     <= ev_d;
      caller_q <= caller_d;
    end
  end

  assign out_s.valid           = out_valid_q;
  assign out_s.event_res       = ev_q;
  assign out_s.exec_count      = hits_q;
  assign out_s.instr_index     = instr_q;
  assign out_s.caller_location = tef_pkg::FIELD_W'(caller_q);
  assign out_s.return_address  = tef_pkg::FIELD_W'(cap_q);

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_FULL)
    else $error("caller stack level beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_wr_en_o |-> level_q < LVL_FULL)
    else $error("push into a full caller stack");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(instr_q) && $stable(hits_q))
    else $error("counters moved without an instruction");

  a_exit_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(inside_q) |-> out_valid_q &&
      (ev_q == tef_pkg::EV_RANGE_EXIT || ev_q == tef_pkg::EV_RETURN))
    else $error("left range or function without an exit event");
`endif

endmodule

`default_nettype wire

// ===== hdl/trace_event_filter.sv =====
// Trace event filter: watches a stream of retired instructions, one per clock
// unless out_o stalls. Input channel in_i carries kind (other, call, return),
// instruction address and call target; output channel out_o carries one result
// per instruction: event code, saturating execution count, one-based instruction
// index, caller location on a traced call, and the captured return address.
// The APB port sets filter mode, match address, range end and root location;
// registers sit at byte addresses 0, 8, 16 and 24. Writing the root location
// also loads the current caller location. Write only while no request is in
// flight.
// An accepted request waits in the input register; the filter logic then loads
// the result register, which presents the valid result. Throughput is one
// instruction per clock while out_o does not stall; the caller stack is a
// single-port-write, registered-read memory whose read port always tracks the
// entry under the top, so a pop completes in the same cycle.
// When out_o stalls, the result register holds and the input register still
// takes one more request; in_i.ready drops only when both are full.
// Reset clears all counters, flags, the stack level, the valid bits and the APB
// registers; the stack contents are not cleared and need no clearing pass.
`default_nettype none

module trace_event_filter #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned ADDR_WIDTH  = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  tef_in_if.sink                            in_i,
  tef_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tef_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tef_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tef_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  tef_pkg::cfg_t          cfg;
  logic                   stk_wr_en;
  logic [IDX_W-1:0]       stk_wr_idx;
  logic [ADDR_WIDTH-1:0]  stk_wr_data;
  logic [IDX_W-1:0]       stk_rd_idx;
  logic [ADDR_WIDTH-1:0]  stk_rd_data;

  tef_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tef_caller_stack #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (ADDR_WIDTH)
  ) u_stack (
    .clk_i     (clk_i),
    .wr_en_i   (stk_wr_en),
    .wr_idx_i  (stk_wr_idx),
    .wr_data_i (stk_wr_data),
    .rd_idx_i  (stk_rd_idx),
    .rd_data_o (stk_rd_data)
  );

  tef_engine #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_s          (in_i),
    .out_s         (out_o),
    .stk_wr_en_o   (stk_wr_en),
    .stk_wr_idx_o  (stk_wr_idx),
    .stk_wr_data_o (stk_wr_data),
    .stk_rd_idx_o  (stk_rd_idx),
    .stk_rd_data_i (stk_rd_data)
  );

endmodule

`default_nettype wire
